/* hw/rtl/bap_pkg.sv */
`default_nettype none
package bap_pkg;

  localparam logic [7:0] PKT_EVENT    = 8'h04;
  localparam logic [7:0] EVT_META     = 8'h3E;
  localparam logic [7:0] SUB_ADV      = 8'h02;
  localparam logic [7:0] SUB_DIRECT   = 8'h0B;
  localparam logic [7:0] TAG_SHORT    = 8'h08;
  localparam logic [7:0] TAG_COMPLETE = 8'h09;
  localparam logic [7:0] KIND_RANDOM  = 8'h01;
  localparam logic [1:0] STATIC_BITS  = 2'b11;
  localparam logic [8:0] REPORT_FIXED = 9'd12;

  // Byte positions inside the packet
  localparam logic [8:0] POS_TYPE     = 9'd0;
  localparam logic [8:0] POS_EVENT    = 9'd1;
  localparam logic [8:0] POS_LENGTH   = 9'd2;
  localparam logic [8:0] POS_SUBEVENT = 9'd3;
  localparam logic [8:0] POS_COUNT    = 9'd4;
  localparam logic [8:0] POS_KIND     = 9'd6;
  localparam logic [8:0] POS_ADDR     = 9'd7;
  localparam logic [8:0] POS_DLEN     = 9'd13;
  localparam logic [8:0] POS_DATA     = 9'd14;

  localparam logic [2:0] ST_ACCEPTED   = 3'd0;
  localparam logic [2:0] ST_BAD_EVENT  = 3'd1;
  localparam logic [2:0] ST_BAD_REPORT = 3'd2;
  localparam logic [2:0] ST_OTHER_SUB  = 3'd3;
  localparam logic [2:0] ST_RANDOM     = 3'd4;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_NAME    = 1'b1;

  typedef enum logic [2:0] {
    PH_SEARCHING = 3'd0,
    PH_TYPE      = 3'd1,
    PH_SKIP      = 3'd2,
    PH_COPY      = 3'd3,
    PH_FOUND     = 3'd4,
    PH_UNKNOWN   = 3'd5
  } walk_phase_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               directed;
    logic               length_mismatch;
    logic               multiple_reports;
    logic [47:0]        device_address;
    logic signed [7:0]  rssi;
    logic               name_state;
    logic [4:0]         name_length;
  } summary_t;

  typedef struct packed {
    summary_t   sum;
    logic [7:0] name_count;
    logic       bank;
  } pkt_rec_t;

  typedef struct packed {
    logic     kind;
    logic     last;
    summary_t sum;
  } stage_t;

endpackage
`default_nettype wire

/* hw/rtl/bap_if.sv */
`default_nettype none
interface bap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;
  modport source (output valid, data_byte, end_of_packet, input ready);
  modport sink (input valid, data_byte, end_of_packet, output ready);
endinterface

interface bap_out_if;
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [2:0]        status;
  logic              directed;
  logic              length_mismatch;
  logic              multiple_reports;
  logic [47:0]       device_address;
  logic signed [7:0] rssi;
  logic              name_state;
  logic [4:0]        name_length;
  logic [7:0]        name_byte;
  logic              last_of_run;
  modport source (output valid, result_kind, status, directed, length_mismatch,
                  multiple_reports, device_address, rssi, name_state, name_length,
                  name_byte, last_of_run, input ready);
  modport sink (input valid, result_kind, status, directed, length_mismatch,
                multiple_reports, device_address, rssi, name_state, name_length,
                name_byte, last_of_run, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bap_ram.sv */
`default_nettype none
module bap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 58
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/bap_front.sv */
`default_nettype none
module bap_front import bap_pkg::*; #(
  parameter int NAME_BYTES = 29,
  parameter int MAX_PACKET = 260,
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    data_byte,
  input  wire logic          end_of_packet,
  output logic               push,
  output pkt_rec_t           push_rec,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [7:0]         ram_wdata
);
  logic [8:0]  byte_count, byte_count_next;
  logic        header_ok, header_ok_next;
  logic [7:0]  declared_length, declared_length_next;
  logic [7:0]  subevent_code, subevent_code_next;
  logic [7:0]  report_count, report_count_next;
  logic [7:0]  address_kind, address_kind_next;
  logic [47:0] address_store, address_store_next;
  logic [7:0]  adv_data_length, adv_data_length_next;
  logic [7:0]  signal_byte, signal_byte_next;
  logic [8:0]  field_start, field_start_next;
  logic [7:0]  field_size, field_size_next;
  walk_phase_t walk_phase, walk_phase_next;
  logic [7:0]  name_count, name_count_next;
  logic        wbank;

  logic [8:0]  p, d, total, rlen, rep_len;
  logic        in_range, in_data, more_data;
  summary_t    sum;

  always_comb begin
    byte_count_next      = byte_count;
    header_ok_next       = header_ok;
    declared_length_next = declared_length;
    subevent_code_next   = subevent_code;
    report_count_next    = report_count;
    address_kind_next    = address_kind;
    address_store_next   = address_store;
    adv_data_length_next = adv_data_length;
    signal_byte_next     = signal_byte;
    field_start_next     = field_start;
    field_size_next      = field_size;
    walk_phase_next      = walk_phase;
    name_count_next      = name_count;
    ram_we               = 1'b0;

    p         = byte_count;
    d         = p - POS_DATA;
    in_range  = (p < 9'(MAX_PACKET));
    in_data   = (p >= POS_DATA) && (d < {1'b0, adv_data_length});
    more_data = ({1'b0, d} + 10'd1) < {2'b0, adv_data_length};

    if (!in_range) begin
      header_ok_next = 1'b0;
    end else begin
      byte_count_next = p + 9'd1;
      if (p == POS_TYPE) begin
        if (data_byte != PKT_EVENT) header_ok_next = 1'b0;
      end else if (p == POS_EVENT) begin
        if (data_byte != EVT_META) header_ok_next = 1'b0;
      end else if (p == POS_LENGTH) begin
        declared_length_next = data_byte;
      end else if (p == POS_SUBEVENT) begin
        subevent_code_next = data_byte;
      end else if (p == POS_COUNT) begin
        report_count_next = data_byte;
      end else if (p == POS_KIND) begin
        address_kind_next = data_byte;
      end else if (p >= POS_ADDR && p < POS_DLEN) begin
        for (int i = 0; i < 6; i++) begin
          if (p == POS_ADDR + 9'(i)) address_store_next[8*i +: 8] = data_byte;
        end
      end else if (p == POS_DLEN) begin
        adv_data_length_next = data_byte;
        walk_phase_next = (data_byte == 8'd0) ? PH_UNKNOWN : PH_SEARCHING;
      end else if (in_data) begin
        unique case (walk_phase)
          PH_SEARCHING: begin
            if (data_byte == 8'd0 ||
                ({1'b0, d} + {2'b0, data_byte} + 10'd1) > {2'b0, adv_data_length}) begin
              walk_phase_next = PH_UNKNOWN;
            end else begin
              field_start_next = d;
              field_size_next  = data_byte;
              walk_phase_next  = PH_TYPE;
            end
          end
          PH_TYPE: begin
            if (data_byte == TAG_SHORT || data_byte == TAG_COMPLETE) begin
              name_count_next = 8'd0;
              if ({1'b0, field_size} > 9'(NAME_BYTES + 1)) walk_phase_next = PH_UNKNOWN;
              else if (field_size == 8'd1) walk_phase_next = PH_FOUND;
              else walk_phase_next = PH_COPY;
            end else if (field_size == 8'd1) begin
              walk_phase_next = more_data ? PH_SEARCHING : PH_UNKNOWN;
            end else begin
              walk_phase_next = PH_SKIP;
            end
          end
          PH_SKIP: begin
            if ({1'b0, d} >= ({1'b0, field_start} + {2'b0, field_size})) begin
              walk_phase_next = more_data ? PH_SEARCHING : PH_UNKNOWN;
            end
          end
          PH_COPY: begin
            ram_we = ({1'b0, name_count} < 9'(NAME_BYTES));
            name_count_next = name_count + 8'd1;
            if (({1'b0, name_count} + 9'd1) >= ({1'b0, field_size} - 9'd1)) begin
              walk_phase_next = PH_FOUND;
            end
          end
          default: ;
        endcase
      end else if (p >= POS_DATA && d == {1'b0, adv_data_length}) begin
        signal_byte_next = data_byte;
      end
    end
    ram_we = ram_we && take;

    // Summary built from the state that includes the closing byte
    total   = byte_count_next;
    rlen    = total - 9'd3;
    rep_len = REPORT_FIXED + {1'b0, adv_data_length_next};
    sum     = '0;
    sum.name_state = 1'b1;
    if (total < 9'd4 || !header_ok_next ||
        ({2'b0, declared_length_next} + 10'd3) != {1'b0, total}) begin
      sum.status = ST_BAD_EVENT;
    end else if (subevent_code_next != SUB_DIRECT && subevent_code_next != SUB_ADV) begin
      sum.status = ST_OTHER_SUB;
    end else begin
      sum.directed = (subevent_code_next == SUB_DIRECT);
      if (rlen < rep_len) begin
        sum.status = ST_BAD_REPORT;
      end else begin
        sum.length_mismatch  = (rlen != rep_len);
        sum.multiple_reports = (report_count_next > 8'd1);
        if (address_kind_next == KIND_RANDOM &&
            address_store_next[47:46] != STATIC_BITS) begin
          sum.status = ST_RANDOM;
        end else begin
          sum.status         = ST_ACCEPTED;
          sum.device_address = address_store_next;
          sum.rssi           = signal_byte_next;
          if (walk_phase_next == PH_FOUND && {1'b0, name_count_next} <= 9'(NAME_BYTES)) begin
            sum.name_state  = 1'b0;
            sum.name_length = name_count_next[4:0];
          end
        end
      end
    end
  end

  assign push               = take && end_of_packet;
  assign push_rec.sum       = sum;
  assign push_rec.bank      = wbank;
  assign push_rec.name_count = (sum.status == ST_ACCEPTED && !sum.name_state) ?
                               name_count_next : 8'd0;
  assign ram_waddr = (wbank ? AW'(NAME_BYTES) : AW'(0)) + AW'(name_count);
  assign ram_wdata = data_byte;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_count      <= '0;
      header_ok       <= 1'b1;
      declared_length <= '0;
      subevent_code   <= '0;
      report_count    <= '0;
      address_kind    <= '0;
      address_store   <= '0;
      adv_data_length <= '0;
      signal_byte     <= '0;
      field_start     <= '0;
      field_size      <= '0;
      walk_phase      <= PH_SEARCHING;
      name_count      <= '0;
    end else if (take) begin
      byte_count      <= byte_count_next;
      header_ok       <= header_ok_next;
      declared_length <= declared_length_next;
      subevent_code   <= subevent_code_next;
      report_count    <= report_count_next;
      address_kind    <= address_kind_next;
      address_store   <= address_store_next;
      adv_data_length <= adv_data_length_next;
      signal_byte     <= signal_byte_next;
      field_start     <= field_start_next;
      field_size      <= field_size_next;
      walk_phase      <= walk_phase_next;
      name_count      <= name_count_next;
    end
    // Flip the name bank once per closed packet
    if (rst) begin
      wbank <= 1'b0;
    end else if (push) begin
      wbank <= !wbank;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/bap_queue.sv */
`default_nettype none
module bap_queue import bap_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire pkt_rec_t push_rec,
  input  wire logic     pop,
  output logic          full,
  output logic          head_valid,
  output pkt_rec_t      head
);
  pkt_rec_t   entry [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_rec;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/bap_back.sv */
`default_nettype none
module bap_back import bap_pkg::*; #(
  parameter int NAME_BYTES = 29,
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire pkt_rec_t      head,
  output logic               pop,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  input  wire logic [7:0]    ram_rdata,
  input  wire logic          out_ready,
  output logic               out_valid,
  output stage_t             out_stage,
  output logic [7:0]         out_name
);
  logic [7:0] idx;
  logic       s1_valid, s1_adv, o_load, issue;
  stage_t     s1, issue_stage;

  assign o_load = s1_valid && (!out_valid || out_ready);
  assign s1_adv = !s1_valid || o_load;
  assign issue  = head_valid && s1_adv;
  assign pop    = issue && (idx == head.name_count);
  assign ram_re = issue && (idx != 8'd0);
  assign ram_raddr = (head.bank ? AW'(NAME_BYTES) : AW'(0)) + AW'(idx - 8'd1);

  always_comb begin
    issue_stage.kind = (idx != 8'd0) ? KIND_NAME : KIND_SUMMARY;
    issue_stage.last = (idx == head.name_count);
    issue_stage.sum  = (idx != 8'd0) ? '0 : head.sum;
  end

  always_ff @(posedge clk) begin
    if (issue) s1 <= issue_stage;
    if (o_load) begin
      out_stage <= s1;
      out_name  <= (s1.kind == KIND_NAME) ? ram_rdata : 8'd0;
    end
    if (rst) begin
      idx       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) idx <= pop ? 8'd0 : idx + 8'd1;
      if (s1_adv) s1_valid <= issue;
      if (o_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/ble_advert_report_parser.sv */
`default_nettype none
// HCI LE advertising-report parser. Takes one HCI event packet byte per cycle on
// the packet channel (end_of_packet marks the last byte) and, after the last byte,
// gives one summary result followed by one result per captured name byte on the
// report channel; last_of_run flags the final result of each packet. The byte
// parser accepts one byte every cycle while the two-entry packet queue has room;
// the emitter gives one result per cycle while report.ready is high, so a
// packet with an n-byte name gives n+1 results. Name bytes sit in a two-bank
// name RAM (2*NAME_BYTES entries), so the next packet is parsed while the
// previous one drains. Parsing stalls only when two closed packets are still
// waiting to drain.
module ble_advert_report_parser import bap_pkg::*; #(
  parameter int NAME_BYTES = 29,
  parameter int MAX_PACKET = 260
) (
  input wire logic clk,
  input wire logic rst,
  bap_in_if.sink   packet,
  bap_out_if.source report
);
  localparam int DEPTH = 2 * NAME_BYTES;
  localparam int AW    = $clog2(DEPTH);

  logic          take, push, pop, full, head_valid;
  pkt_rec_t      push_rec, head;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata, out_name;
  stage_t        out_stage;

  // Hold off bytes while both name banks are owned by queued packets
  assign packet.ready = !full;
  assign take         = packet.valid && packet.ready;

  bap_front #(.NAME_BYTES(NAME_BYTES), .MAX_PACKET(MAX_PACKET), .AW(AW)) u_front (
    .clk, .rst, .take,
    .data_byte     (packet.data_byte),
    .end_of_packet (packet.end_of_packet),
    .push, .push_rec, .ram_we, .ram_waddr, .ram_wdata
  );

  bap_queue u_queue (
    .clk, .rst, .push, .push_rec, .pop, .full, .head_valid, .head
  );

  bap_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_name_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  bap_back #(.NAME_BYTES(NAME_BYTES), .AW(AW)) u_back (
    .clk, .rst, .head_valid, .head, .pop, .ram_re, .ram_raddr, .ram_rdata,
    .out_ready (report.ready),
    .out_valid (report.valid),
    .out_stage, .out_name
  );

  // Drive the result fields from the output register
  assign report.result_kind      = out_stage.kind;
  assign report.status           = out_stage.sum.status;
  assign report.directed         = out_stage.sum.directed;
  assign report.length_mismatch  = out_stage.sum.length_mismatch;
  assign report.multiple_reports = out_stage.sum.multiple_reports;
  assign report.device_address   = out_stage.sum.device_address;
  assign report.rssi             = out_stage.sum.rssi;
  assign report.name_state       = out_stage.sum.name_state;
  assign report.name_length      = out_stage.sum.name_length;
  assign report.name_byte        = out_name;
  assign report.last_of_run      = out_stage.last;
endmodule
`default_nettype wire

/* hw/rtl/bap_checker.sv */
`default_nettype none
module bap_checker import bap_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        result_kind,
  input wire logic [2:0]  status,
  input wire logic [47:0] device_address,
  input wire logic        name_state,
  input wire logic [4:0]  name_length,
  input wire logic        last_of_run
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last_of_run))
    else $error("stalled result changed");

  a_name_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_NAME |->
      status == ST_ACCEPTED && device_address == '0 && name_state == 1'b0)
    else $error("name byte result carries summary fields");

  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_SUMMARY && status != ST_ACCEPTED |->
      last_of_run && name_state && name_length == 5'd0)
    else $error("rejected packet not closed by its summary");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind ble_advert_report_parser bap_checker u_bap_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (report.valid),
  .out_ready      (report.ready),
  .result_kind    (report.result_kind),
  .status         (report.status),
  .device_address (report.device_address),
  .name_state     (report.name_state),
  .name_length    (report.name_length),
  .last_of_run    (report.last_of_run)
);
`default_nettype wire

/* sim/ble_advert_report_parser_test.sv */
`timescale 1ns / 100ps
module ble_advert_report_parser_test;
  import bap_pkg::*;

  localparam int NAME_MAX   = 29;
  localparam int PKT_MAX    = 64;
  localparam int CYCLE_CAP  = 400000;
  localparam int NO_STATUS  = -1;

  // One result as seen on the report channel
  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic        directed;
    logic        mismatch;
    logic        multi;
    logic [47:0] addr;
    logic [7:0]  rssi;
    logic        name_unknown;
    logic [4:0]  name_size;
    logic [7:0]  name_byte;
    logic        last;
  } report_item_t;

  // Directed cases, one per row of the stimulus table
  typedef enum int {
    C_LONE_BYTE, C_BAD_TYPE, C_BAD_EVENT, C_BAD_LENGTH, C_OTHER_SUB, C_SHORT_REPORT,
    C_RANDOM_NONSTATIC, C_RANDOM_STATIC, C_DIRECTED, C_MISMATCH_MULTI, C_ZERO_FIELD,
    C_NAME_TOO_LONG, C_NAME_EMPTY, C_FIELD_OVERRUN, C_NO_NAME, C_NAME_FULL,
    C_RSSI_MIN, C_ALL_ONES, C_SKIP_THEN_NAME, C_OVERLONG, C_NO_DATA
  } case_e;

  typedef struct {
    case_e code;
    int    status;  // NO_STATUS: rely on the predictor alone
  } case_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bap_in_if  pkt_if();
  bap_out_if rep_if();

  ble_advert_report_parser #(.NAME_BYTES(NAME_MAX), .MAX_PACKET(PKT_MAX)) uut (
    .clk(clk),
    .rst(rst),
    .packet(pkt_if.sink),
    .report(rep_if.source)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser shadow: mirrors the block's per-packet state, one byte at a time
  // ---------------------------------------------------------------------------
  int          byte_cnt;
  bit          hdr_ok;
  int          decl_len;
  int          sub_code;
  int          rep_cnt;
  int          addr_kind;
  logic [47:0] addr_acc;
  int          data_len;
  logic [7:0]  rssi_byte;
  int          fld_start;
  int          fld_size;
  walk_phase_t phase;
  logic [7:0]  name_buf [NAME_MAX];
  int          name_cnt;

  report_item_t report_q[$];   // results still owed by the block
  int           status_q[$];   // typed-in summary status per packet, or NO_STATUS
  int           errors = 0;
  int           results_seen = 0;
  int           packets_sent = 0;
  int           bytes_sent = 0;

  function automatic void clear_packet();
    byte_cnt  = 0;
    hdr_ok    = 1'b1;
    decl_len  = 0;
    sub_code  = 0;
    rep_cnt   = 0;
    addr_kind = 0;
    addr_acc  = '0;
    data_len  = 0;
    rssi_byte = '0;
    fld_start = 0;
    fld_size  = 0;
    phase     = PH_SEARCHING;
    name_cnt  = 0;
  endfunction

  // Move on after the last byte of a field at data offset d
  function automatic void field_done(int d);
    phase = (d + 1 < data_len) ? PH_SEARCHING : PH_UNKNOWN;
  endfunction

  function automatic void walk_fields(int d, int b);
    case (phase)
      PH_SEARCHING: begin
        if (b == 0 || d + b + 1 > data_len) begin
          phase = PH_UNKNOWN;
        end else begin
          fld_start = d;
          fld_size  = b;
          phase     = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (b == TAG_SHORT || b == TAG_COMPLETE) begin
          name_cnt = 0;
          if (fld_size - 1 > NAME_MAX) phase = PH_UNKNOWN;
          else if (fld_size == 1) phase = PH_FOUND;
          else phase = PH_COPY;
        end else if (fld_size == 1) begin
          field_done(d);
        end else begin
          phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (d >= fld_start + fld_size) field_done(d);
      end
      PH_COPY: begin
        if (name_cnt < NAME_MAX) name_buf[name_cnt] = b[7:0];
        name_cnt++;
        if (name_cnt >= fld_size - 1) phase = PH_FOUND;
      end
      default: ;
    endcase
  endfunction

  // Update the shadow with one accepted byte; on the end mark, queue the
  // summary and name bytes the block owes for this packet.
  function automatic void parse_byte(logic [7:0] b, logic eop);
    int           p;
    int           total;
    int           nlen;
    report_item_t r;
    p = byte_cnt;
    if (p >= PKT_MAX) begin
      hdr_ok = 1'b0;  // overlong: drop the byte
    end else begin
      byte_cnt = p + 1;
      if (p == POS_TYPE) begin
        if (b != PKT_EVENT) hdr_ok = 1'b0;
      end else if (p == POS_EVENT) begin
        if (b != EVT_META) hdr_ok = 1'b0;
      end else if (p == POS_LENGTH) begin
        decl_len = b;
      end else if (p == POS_SUBEVENT) begin
        sub_code = b;
      end else if (p == POS_COUNT) begin
        rep_cnt = b;
      end else if (p == POS_KIND) begin
        addr_kind = b;
      end else if (p >= POS_ADDR && p < POS_DLEN) begin
        addr_acc[8*(p-POS_ADDR) +: 8] = b;
      end else if (p == POS_DLEN) begin
        data_len = b;
        phase    = (b == 0) ? PH_UNKNOWN : PH_SEARCHING;
      end else if (p >= POS_DATA) begin
        if (p - POS_DATA < data_len) walk_fields(p - POS_DATA, b);
        else if (p - POS_DATA == data_len) rssi_byte = b;
      end
    end
    if (!eop) return;

    r = '0;
    r.kind = KIND_SUMMARY;
    r.name_unknown = 1'b1;
    nlen = 0;
    total = byte_cnt;
    if (total < 4 || !hdr_ok || decl_len + 3 != total) begin
      r.status = ST_BAD_EVENT;
    end else if (sub_code != SUB_DIRECT && sub_code != SUB_ADV) begin
      r.status = ST_OTHER_SUB;
    end else begin
      r.directed = (sub_code == SUB_DIRECT);
      if (total - 3 < REPORT_FIXED + data_len) begin
        r.status = ST_BAD_REPORT;
      end else begin
        r.mismatch = (total - 3 != REPORT_FIXED + data_len);
        r.multi    = (rep_cnt > 1);
        if (addr_kind == KIND_RANDOM && addr_acc[47:46] != STATIC_BITS) begin
          r.status = ST_RANDOM;
        end else begin
          r.status = ST_ACCEPTED;
          r.addr   = addr_acc;
          r.rssi   = rssi_byte;
          if (phase == PH_FOUND && name_cnt <= NAME_MAX) begin
            r.name_unknown = 1'b0;
            nlen = name_cnt;
          end
        end
      end
    end
    r.name_size = nlen[4:0];
    r.last      = (nlen == 0);
    report_q.push_back(r);
    for (int k = 0; k < nlen; k++) begin
      r = '0;
      r.kind      = KIND_NAME;
      r.name_byte = name_buf[k];
      r.last      = (k + 1 == nlen);
      report_q.push_back(r);
    end
    clear_packet();
  endfunction

  // ---------------------------------------------------------------------------
  // Packet channel driver
  // ---------------------------------------------------------------------------
  bit in_busy_mode = 1'b1;  // when clear, no gaps between transfers

  // Call at a rising edge; returns at the edge of the transfer.
  task automatic send_byte(logic [7:0] b, logic eop);
    int gap;
    gap = in_busy_mode ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      pkt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pkt_if.valid         <= 1'b1;
    pkt_if.data_byte     <= b;
    pkt_if.end_of_packet <= eop;
    @(posedge clk);
    while (!pkt_if.ready) @(posedge clk);
    parse_byte(b, eop);
    bytes_sent++;
  endtask

  task automatic send_packet(const ref logic [7:0] bytes[$], input int exp_status);
    status_q.push_back(exp_status);
    in_busy_mode = ($urandom_range(0, 3) != 0);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    packets_sent++;
  endtask

  // Assemble a report packet around the given advertising data. len_adj skews
  // the header length byte, dlen_adj the data length byte.
  function automatic void make_report(ref logic [7:0] q[$], input logic [7:0] sub,
                                      input logic [7:0] count, input logic [7:0] kind,
                                      input logic [47:0] addr, const ref logic [7:0] data[$],
                                      input logic [7:0] rssi, input int extra,
                                      input int len_adj, input int dlen_adj);
    q = {PKT_EVENT, EVT_META, 8'h00, sub, count, 8'($urandom), kind};
    for (int i = 0; i < 6; i++) q.push_back(addr[8*i +: 8]);
    q.push_back(8'(data.size() + dlen_adj));
    foreach (data[i]) q.push_back(data[i]);
    q.push_back(rssi);
    repeat (extra) q.push_back(8'($urandom));
    q[2] = 8'(q.size() - 3 + len_adj);
  endfunction

  function automatic void add_field(ref logic [7:0] data[$], input logic [7:0] tag,
                                    input int payload);
    data.push_back(8'(payload + 1));
    data.push_back(tag);
    repeat (payload) data.push_back(8'($urandom));
  endfunction

  function automatic logic [47:0] rand_addr();
    return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
  endfunction

  // Well-formed packet with random content; a minority is broken on purpose
  function automatic void random_packet(ref logic [7:0] q[$]);
    logic [7:0]  data[$];
    logic [7:0]  sub;
    logic [7:0]  kind;
    logic [47:0] addr;
    int          flavor;
    int          nfields;
    flavor = $urandom_range(0, 19);
    if (flavor == 0) begin
      // noise: random bytes of random length
      q = {};
      repeat ($urandom_range(1, 20)) q.push_back(8'($urandom));
      return;
    end
    data = {};
    nfields = $urandom_range(0, 3);
    repeat (nfields) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_field(data, TAG_COMPLETE, $urandom_range(0, 12));
        3, 4:    add_field(data, TAG_SHORT, $urandom_range(0, 12));
        5:       add_field(data, TAG_COMPLETE, $urandom_range(26, 31));
        6:       data.push_back(8'h00);
        default: add_field(data, 8'($urandom), $urandom_range(0, 6));
      endcase
    end
    if ($urandom_range(0, 7) == 0) data.push_back(8'($urandom)); // dangling length
    sub  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : ($urandom_range(0, 1) ? SUB_ADV
                                                                             : SUB_DIRECT);
    kind = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
    addr = rand_addr();
    if ($urandom_range(0, 1)) addr[47:46] = 2'b11;
    make_report(q, sub, 8'($urandom_range(0, 3)), kind, addr, data, 8'($urandom),
                ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0,
                (flavor == 1) ? $urandom_range(1, 3) : 0,
                (flavor == 2) ? $urandom_range(1, 4) : 0);
    // flip one byte now and then
    if (flavor == 3) q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Report channel: random stalls, checks against the oldest expectation
  // ---------------------------------------------------------------------------
  int  stall_left = 0;
  bit  out_busy_mode = 1'b1;
  int  cycle_cnt = 0;

  always @(posedge clk) begin
    report_item_t got;
    report_item_t exp;
    int           typed;
    logic         ready_next;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("%0t: timeout, %0d results still owed", $time, report_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    ready_next = rep_if.ready;
    if (!rst && rep_if.valid && rep_if.ready) begin
      got = '{rep_if.result_kind, rep_if.status, rep_if.directed, rep_if.length_mismatch,
              rep_if.multiple_reports, rep_if.device_address, rep_if.rssi,
              rep_if.name_state, rep_if.name_length, rep_if.name_byte, rep_if.last_of_run};
      results_seen++;
      if (report_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        exp = report_q.pop_front();
        if (got !== exp) begin
          $display("%0t: result mismatch\n  expected %p\n  actual   %p", $time, exp, got);
          errors++;
        end
        if (exp.kind == KIND_SUMMARY && status_q.size() > 0) begin
          typed = status_q.pop_front();
          if (typed != NO_STATUS && got.status !== 3'(typed)) begin
            $display("%0t: status mismatch, expected %0d actual %0d", $time, typed,
                     got.status);
            errors++;
          end
        end
      end
      // draw the stall before the next result; switch modes now and then
      if (results_seen % 40 == 0) out_busy_mode = ~out_busy_mode;
      stall_left = out_busy_mode ? $urandom_range(0, 12) : 0;
      ready_next = (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      ready_next = (stall_left == 0);
    end else begin
      ready_next = 1'b1;
    end
    rep_if.ready <= ready_next;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  case_row_t cases[] = '{
    '{C_LONE_BYTE,        ST_BAD_EVENT},
    '{C_BAD_TYPE,         ST_BAD_EVENT},
    '{C_BAD_EVENT,        ST_BAD_EVENT},
    '{C_BAD_LENGTH,       ST_BAD_EVENT},
    '{C_OTHER_SUB,        ST_OTHER_SUB},
    '{C_SHORT_REPORT,     ST_BAD_REPORT},
    '{C_RANDOM_NONSTATIC, ST_RANDOM},
    '{C_RANDOM_STATIC,    ST_ACCEPTED},
    '{C_DIRECTED,         ST_ACCEPTED},
    '{C_MISMATCH_MULTI,   ST_ACCEPTED},
    '{C_ZERO_FIELD,       NO_STATUS},
    '{C_NAME_TOO_LONG,    NO_STATUS},
    '{C_NAME_EMPTY,       NO_STATUS},
    '{C_FIELD_OVERRUN,    NO_STATUS},
    '{C_NO_NAME,          NO_STATUS},
    '{C_NAME_FULL,        NO_STATUS},
    '{C_RSSI_MIN,         NO_STATUS},
    '{C_ALL_ONES,         NO_STATUS},
    '{C_SKIP_THEN_NAME,   NO_STATUS},
    '{C_OVERLONG,         ST_BAD_EVENT},
    '{C_NO_DATA,          NO_STATUS}
  };

  initial begin
    logic [7:0]  pkt[$];
    logic [7:0]  data[$];
    logic [47:0] addr;
    int          drain;
    pkt_if.valid         = 1'b0;
    pkt_if.data_byte     = '0;
    pkt_if.end_of_packet = 1'b0;
    clear_packet();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases: extremes and every special case of the parser
    foreach (cases[i]) begin
      data = {};
      addr = rand_addr();
      addr[47:46] = 2'b11;
      case (cases[i].code)
        C_LONE_BYTE: pkt = {8'h00};
        C_BAD_TYPE: begin
          add_field(data, TAG_COMPLETE, 3);
          make_report(pkt, SUB_ADV, 1, 0, addr, data, 8'h10, 0, 0, 0);
          pkt[0] = 8'hFF;
        end
        C_BAD_EVENT: begin
          make_report(pkt, SUB_ADV, 1, 0, addr, data, 8'h10, 0, 0, 0);
          pkt[1] = 8'h3F;
        end
        C_BAD_LENGTH: make_report(pkt, SUB_ADV, 1, 0, addr, data, 8'h10, 0, 1, 0);
        C_OTHER_SUB:  make_report(pkt, 8'hFF, 1, 0, addr, data, 8'h10, 0, 0, 0);
        C_SHORT_REPORT: begin
          add_field(data, TAG_SHORT, 2);
          make_report(pkt, SUB_ADV, 1, 0, addr, data, 8'h10, 0, 0, 3);
        end
        C_RANDOM_NONSTATIC: begin
          addr[47:46] = 2'b10;
          make_report(pkt, SUB_ADV, 1, KIND_RANDOM, addr, data, 8'h10, 0, 0, 0);
        end
        C_RANDOM_STATIC: begin
          add_field(data, TAG_COMPLETE, 4);
          make_report(pkt, SUB_ADV, 1, KIND_RANDOM, addr, data, 8'h7F, 0, 0, 0);
        end
        C_DIRECTED: make_report(pkt, SUB_DIRECT, 1, 0, addr, data, 8'h80, 0, 0, 0);
        C_MISMATCH_MULTI: begin
          add_field(data, TAG_SHORT, 5);
          make_report(pkt, SUB_ADV, 8'hFF, 0, addr, data, 8'h01, 2, 0, 0);
        end
        C_ZERO_FIELD: begin
          data = {8'h00, 8'h03, TAG_COMPLETE, 8'h41, 8'h42};
          make_report(pkt, SUB_ADV, 1, 0, addr, data, 8'h20, 0, 0, 0);
        end
        C_NAME_TOO_LONG: begin
          add_field(data, TAG_COMPLETE, NAME_MAX + 1);
          make_report(pkt, SUB_ADV, 1, 0, addr, data, 8'h20, 0, 0, 0);
        end
        C_NAME_EMPTY: begin
          add_field(data, TAG_SHORT, 0);
          make_report(pkt, SUB_ADV, 1, 0, addr, data, 8'h20, 0, 0, 0);
        end
        C_FIELD_OVERRUN: begin
          data = {8'h02, 8'h01, 8'h05, TAG_COMPLETE, 8'h41, 8'h42};
          make_report(pkt, SUB_ADV, 1, 0, addr, data, 8'h20, 0, 0, 0);
        end
        C_NO_NAME: begin
          add_field(data, 8'h01, 1);
          add_field(data, 8'hFF, 3);
          make_report(pkt, SUB_ADV, 1, 0, addr, data, 8'h20, 0, 0, 0);
        end
        C_NAME_FULL: begin
          add_field(data, TAG_COMPLETE, NAME_MAX);
          make_report(pkt, SUB_DIRECT, 1, 0, addr, data, 8'h20, 0, 0, 0);
        end
        C_RSSI_MIN: begin
          add_field(data, TAG_SHORT, 1);
          make_report(pkt, SUB_ADV, 0, 0, '0, data, 8'h80, 0, 0, 0);
        end
        C_ALL_ONES: begin
          add_field(data, TAG_COMPLETE, 6);
          foreach (data[j]) if (j > 1) data[j] = 8'hFF;
          make_report(pkt, SUB_ADV, 1, KIND_RANDOM, '1, data, 8'hFF, 0, 0, 0);
        end
        C_SKIP_THEN_NAME: begin
          add_field(data, 8'h01, 0);
          add_field(data, 8'hFF, 4);
          add_field(data, TAG_SHORT, 7);
          add_field(data, TAG_COMPLETE, 3);
          make_report(pkt, SUB_ADV, 1, 0, addr, data, 8'h33, 0, 0, 0);
        end
        C_OVERLONG: begin
          // runs past the packet bound; the extra bytes are dropped
          pkt = {PKT_EVENT, EVT_META, 8'hFF};
          while (pkt.size() < PKT_MAX + 2) pkt.push_back(8'($urandom));
        end
        default: make_report(pkt, SUB_ADV, 1, 0, addr, data, 8'h7F, 0, 0, 0);
      endcase
      send_packet(pkt, cases[i].status);
    end

    // Random part: mostly well-formed reports, until at least 560 bytes are sent
    while (bytes_sent < 560 || packets_sent < cases.size() + 4) begin
      random_packet(pkt);
      send_packet(pkt, NO_STATUS);
    end
    pkt_if.valid         <= 1'b0;
    pkt_if.end_of_packet <= 1'b0;

    // Drain, then keep watching for anything stray
    drain = 0;
    while (report_q.size() > 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (30) @(posedge clk);
    if (report_q.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, report_q.size());
      errors++;
    end

    $display("Sent %0d packets (%0d bytes) incl. header, length, address and name cases;",
             packets_sent, bytes_sent);
    $display("checked %0d results, %0d errors", results_seen, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* ble_advert_report_parser.f */
hw/rtl/bap_pkg.sv
hw/rtl/bap_if.sv
hw/rtl/bap_ram.sv
hw/rtl/bap_front.sv
hw/rtl/bap_queue.sv
hw/rtl/bap_back.sv
hw/rtl/ble_advert_report_parser.sv
hw/rtl/bap_checker.sv
sim/ble_advert_report_parser_test.sv
